// ===== src/spd_pkg.sv =====
// Shared constants, types and CRC function for the servo packet deframer.
`timescale 1ns / 1ps
package spd_pkg;

   localparam int MAX_PARAMS_DEF = 64;
   localparam int CNT_W          = 6;
   localparam int POS_W          = 7;

   localparam logic [7:0]  HDR_SYNC     = 8'hFF;
   localparam logic [7:0]  HDR_MARK     = 8'hFD;
   localparam logic [7:0]  HDR_RSVD     = 8'h00;
   localparam logic [15:0] CRC_POLY     = 16'h8005;
   localparam logic [15:0] LEN_OVERHEAD = 16'd3;

   // packet handed from the framer to the emitter on a good check
   typedef struct packed {
      logic             start;
      logic [7:0]       id;
      logic [7:0]       instr;
      logic [CNT_W-1:0] count;
   } spd_pkt_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] addr;
      logic [7:0]       data;
   } spd_wr_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] addr;
   } spd_rd_type;

   // CRC-16, poly 0x8005, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/spd_param_ram.sv =====
// Parameter byte store: one write port, one registered read port.
`timescale 1ns / 1ps
module spd_param_ram
   import spd_pkg::*;
#(
   parameter int DEPTH = MAX_PARAMS_DEF
) (
   input  logic       clock,
   input  spd_wr_type wr,
   input  spd_rd_type rd,
   output logic [7:0] rdata
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/spd_framer.sv =====
// Byte framer: header hunt, field capture, CRC and parameter store writes.
`timescale 1ns / 1ps
module spd_framer
   import spd_pkg::*;
#(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_acc,
   input  logic [7:0]  byte_data,
   output spd_wr_type  wr,
   output spd_pkt_type pkt
);

   localparam logic [POS_W-1:0] POS_HDR_MARK = POS_W'(2);
   localparam logic [POS_W-1:0] POS_HDR_RSVD = POS_W'(3);
   localparam logic [POS_W-1:0] POS_ID       = POS_W'(4);
   localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(5);
   localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(6);
   localparam logic [POS_W-1:0] POS_INSTR    = POS_W'(7);
   localparam logic [POS_W-1:0] POS_PARAM    = POS_W'(8);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [7:0]       instr_ff, instr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       chk_lo_ff, chk_lo_in;

   logic [POS_W-1:0] off;
   logic [15:0]      len;
   logic [15:0]      len_m3;
   logic [7:0]       want;

   assign off    = pos_ff - POS_PARAM;
   assign len    = {byte_data, len_lo_ff};
   assign len_m3 = len - LEN_OVERHEAD;
   assign want   = (pos_ff == POS_HDR_MARK) ? HDR_MARK :
                   (pos_ff == POS_HDR_RSVD) ? HDR_RSVD : HDR_SYNC;

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      id_in     = id_ff;
      len_lo_in = len_lo_ff;
      instr_in  = instr_ff;
      cnt_in    = cnt_ff;
      chk_lo_in = chk_lo_ff;
      wr.en     = 1'b0;
      wr.addr   = off[CNT_W-1:0];
      wr.data   = byte_data;
      pkt.start = 1'b0;
      pkt.id    = id_ff;
      pkt.instr = instr_ff;
      pkt.count = cnt_ff;
      if (byte_acc) begin
         if (pos_ff <= POS_HDR_RSVD) begin
            if (byte_data != want) begin
               pos_in = '0;
               crc_in = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
               crc_in = crc16_byte(crc_ff, byte_data);
            end
         end else if (pos_ff == POS_LEN_HI &&
                      (len < LEN_OVERHEAD || len_m3 >= 16'(MAX_PARAMS))) begin
            pos_in = '0;
            crc_in = '0;
         end else if (pos_ff >= POS_PARAM && off == {1'b0, cnt_ff}) begin
            // low check byte is not covered by the CRC
            chk_lo_in = byte_data;
            pos_in    = pos_ff + POS_W'(1);
         end else if (pos_ff >= POS_PARAM && off > {1'b0, cnt_ff}) begin
            pos_in    = '0;
            crc_in    = '0;
            pkt.start = ({byte_data, chk_lo_ff} == crc_ff);
         end else begin
            pos_in = pos_ff + POS_W'(1);
            crc_in = crc16_byte(crc_ff, byte_data);
            if (pos_ff == POS_ID) begin
               id_in = byte_data;
            end else if (pos_ff == POS_LEN_LO) begin
               len_lo_in = byte_data;
            end else if (pos_ff == POS_LEN_HI) begin
               cnt_in = len_m3[CNT_W-1:0];
            end else if (pos_ff == POS_INSTR) begin
               instr_in = byte_data;
            end else begin
               wr.en = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      len_lo_ff <= len_lo_in;
      instr_ff  <= instr_in;
      cnt_ff    <= cnt_in;
      chk_lo_ff <= chk_lo_in;
   end

endmodule

// ===== src/spd_emitter.sv =====
// Result sequencer: reads buffered parameters back and drives the result register.
`timescale 1ns / 1ps
module spd_emitter
   import spd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  spd_pkt_type      pkt,
   input  logic [7:0]       rdata,
   output spd_rd_type       rd,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_packet_id,
   output logic [7:0]       rsp_instruction_code,
   output logic [CNT_W-1:0] rsp_param_count,
   output logic             rsp_param_present,
   output logic [CNT_W-1:0] rsp_param_index,
   output logic [7:0]       rsp_param_value,
   output logic             rsp_last_of_packet
);

   logic             busy_ff, busy_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       instr_ff, instr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic             pend_ff, pend_in;
   logic             pend_present_ff, pend_present_in;
   logic [CNT_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_last_ff, pend_last_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_id_ff, out_id_in;
   logic [7:0]       out_instr_ff, out_instr_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic             out_present_ff, out_present_in;
   logic [CNT_W-1:0] out_idx_ff, out_idx_in;
   logic [7:0]       out_value_ff, out_value_in;
   logic             out_last_ff, out_last_in;

   logic issue;
   logic empty_pkt;
   logic is_last;

   assign empty_pkt = (cnt_ff == '0);
   assign is_last   = empty_pkt || (idx_ff + CNT_W'(1) == cnt_ff);
   // one read in flight at a time; issue only when the result register frees up
   assign issue     = busy_ff && !pend_ff && (!out_valid_ff || !rsp_stall);

   assign rd.en   = issue && !empty_pkt;
   assign rd.addr = idx_ff;

   always_comb begin
      busy_in         = busy_ff;
      id_in           = id_ff;
      instr_in        = instr_ff;
      cnt_in          = cnt_ff;
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      pend_present_in = pend_present_ff;
      pend_idx_in     = pend_idx_ff;
      pend_last_in    = pend_last_ff;
      if (pkt.start) begin
         busy_in  = 1'b1;
         id_in    = pkt.id;
         instr_in = pkt.instr;
         cnt_in   = pkt.count;
         idx_in   = '0;
      end else if (issue) begin
         pend_in         = 1'b1;
         pend_present_in = !empty_pkt;
         pend_idx_in     = idx_ff;
         pend_last_in    = is_last;
         idx_in          = idx_ff + CNT_W'(1);
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_id_in      = out_id_ff;
      out_instr_in   = out_instr_ff;
      out_cnt_in     = out_cnt_ff;
      out_present_in = out_present_ff;
      out_idx_in     = out_idx_ff;
      out_value_in   = out_value_ff;
      out_last_in    = out_last_ff;
      if (pend_ff) begin
         out_valid_in   = 1'b1;
         out_id_in      = id_ff;
         out_instr_in   = instr_ff;
         out_cnt_in     = cnt_ff;
         out_present_in = pend_present_ff;
         out_idx_in     = pend_idx_ff;
         out_value_in   = pend_present_ff ? rdata : 8'h00;
         out_last_in    = pend_last_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff           <= id_in;
      instr_ff        <= instr_in;
      cnt_ff          <= cnt_in;
      idx_ff          <= idx_in;
      pend_present_ff <= pend_present_in;
      pend_idx_ff     <= pend_idx_in;
      pend_last_ff    <= pend_last_in;
      out_id_ff       <= out_id_in;
      out_instr_ff    <= out_instr_in;
      out_cnt_ff      <= out_cnt_in;
      out_present_ff  <= out_present_in;
      out_idx_ff      <= out_idx_in;
      out_value_ff    <= out_value_in;
      out_last_ff     <= out_last_in;
   end

   assign busy                 = busy_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_packet_id        = out_id_ff;
   assign rsp_instruction_code = out_instr_ff;
   assign rsp_param_count      = out_cnt_ff;
   assign rsp_param_present    = out_present_ff;
   assign rsp_param_index      = out_idx_ff;
   assign rsp_param_value      = out_value_ff;
   assign rsp_last_of_packet   = out_last_ff;

endmodule

// ===== src/servo_packet_deframer_crc16.sv =====
// Servo packet deframer with CRC-16 check: top level.
//
// Received bytes are taken one per clock while a packet is being hunted for or
// received; header FF FF FD 00, id, 16-bit length, instruction, parameters and a
// little-endian CRC-16 (0x8005, init 0) are checked on the fly and parameter bytes
// are written into a single-port-write parameter RAM. After a packet with a good
// check, req_stall goes high while the result sequencer reads the RAM back: each
// result is one RAM read followed by one load of the result register, and the next
// read waits for that load; a packet with no parameters still gives one result. The
// input is held until the last read is issued, and longer while rsp_stall holds a
// waiting result. A bad or malformed packet produces no results and never stalls
// the input. The RAM needs no clearing pass; only entries written by the current
// packet are read.
`timescale 1ns / 1ps
module servo_packet_deframer_crc16
   import spd_pkg::*;
#(
   parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_packet_id,
   output logic [7:0]       rsp_instruction_code,
   output logic [CNT_W-1:0] rsp_param_count,
   output logic             rsp_param_present,
   output logic [CNT_W-1:0] rsp_param_index,
   output logic [7:0]       rsp_param_value,
   output logic             rsp_last_of_packet
);

   logic        busy;
   logic        byte_acc;
   spd_wr_type  wr;
   spd_rd_type  rd;
   spd_pkt_type pkt;
   logic [7:0]  rdata;

   assign req_stall = busy;
   assign byte_acc  = req_valid && !busy;

   spd_framer #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_framer (
      .clock     (clock),
      .reset     (reset),
      .byte_acc  (byte_acc),
      .byte_data (req_rx_byte),
      .wr        (wr),
      .pkt       (pkt)
   );

   spd_param_ram #(
      .DEPTH(MAX_PARAMS)
   ) u_param_ram (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (rdata)
   );

   spd_emitter u_emitter (
      .clock                (clock),
      .reset                (reset),
      .pkt                  (pkt),
      .rdata                (rdata),
      .rd                   (rd),
      .busy                 (busy),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_packet_id        (rsp_packet_id),
      .rsp_instruction_code (rsp_instruction_code),
      .rsp_param_count      (rsp_param_count),
      .rsp_param_present    (rsp_param_present),
      .rsp_param_index      (rsp_param_index),
      .rsp_param_value      (rsp_param_value),
      .rsp_last_of_packet   (rsp_last_of_packet)
   );

endmodule
